FILE: src/swce_pkg.sv
// swce_pkg: shared types, opcodes, register addresses and the duty table
// for the square wave channel; no dependencies
`default_nettype none

package swce_pkg;

	localparam logic [2:0] OP_WRITE    = 3'd0;
	localparam logic [2:0] OP_READ     = 3'd1;
	localparam logic [2:0] OP_TICK     = 3'd2;
	localparam logic [2:0] OP_LENGTH   = 3'd3;
	localparam logic [2:0] OP_ENVELOPE = 3'd4;

	localparam logic [7:0] ADDR_DUTY   = 8'h16;
	localparam logic [7:0] ADDR_ENV    = 8'h17;
	localparam logic [7:0] ADDR_FLO    = 8'h18;
	localparam logic [7:0] ADDR_FHI    = 8'h19;

	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = 2;
	localparam int RQ_DEPTH = 2;
	localparam int RQ_AW    = 1;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] reg_address;
		logic [7:0] write_data;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [3:0] sample_out;
		logic       channel_on;
	} out_beat_t;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_WR_DUTY,
		CMD_WR_ENV,
		CMD_WR_FLO,
		CMD_WR_FHI,
		CMD_RD_DUTY,
		CMD_RD_ENV,
		CMD_RD_FHI,
		CMD_TICK,
		CMD_LENGTH,
		CMD_ENVELOPE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_beat_t;

	function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
		logic [7:0] pat;
		case (sel)
			2'd0: pat = 8'h01;
			2'd1: pat = 8'h81;
			2'd2: pat = 8'h87;
			default: pat = 8'h7E;
		endcase
		return pat;
	endfunction

endpackage

`default_nettype wire

FILE: src/swce_front.sv
// swce_front: decodes incoming beats into channel commands and holds them
// in a short command queue; depends on swce_pkg
`default_nettype none

module swce_front
	import swce_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	output logic           full,
	input  wire in_beat_t  item,
	output cmd_beat_t      cmd,
	input  wire logic      take
);

	cmd_t                cmd_dec;
	cmd_t                mem_q [CQ_DEPTH];
	logic [CQ_AW-1:0]    wr_ptr_q;
	logic [CQ_AW-1:0]    rd_ptr_q;
	logic [CQ_AW:0]      count_q;
	logic                push_ok;
	logic                pop_ok;

	always_comb begin
		cmd_dec.data = item.write_data;
		cmd_dec.op   = CMD_NOP;
		case (item.opcode)
			OP_WRITE: begin
				case (item.reg_address)
					ADDR_DUTY: cmd_dec.op = CMD_WR_DUTY;
					ADDR_ENV:  cmd_dec.op = CMD_WR_ENV;
					ADDR_FLO:  cmd_dec.op = CMD_WR_FLO;
					ADDR_FHI:  cmd_dec.op = CMD_WR_FHI;
					default:   cmd_dec.op = CMD_NOP;
				endcase
			end
			OP_READ: begin
				case (item.reg_address)
					ADDR_DUTY: cmd_dec.op = CMD_RD_DUTY;
					ADDR_ENV:  cmd_dec.op = CMD_RD_ENV;
					ADDR_FHI:  cmd_dec.op = CMD_RD_FHI;
					default:   cmd_dec.op = CMD_NOP;
				endcase
			end
			OP_TICK:     cmd_dec.op = CMD_TICK;
			OP_LENGTH:   cmd_dec.op = CMD_LENGTH;
			OP_ENVELOPE: cmd_dec.op = CMD_ENVELOPE;
			default:     cmd_dec.op = CMD_NOP;
		endcase
	end

	assign full      = (count_q == (CQ_AW+1)'(CQ_DEPTH));
	assign push_ok   = push && !full;
	assign cmd.valid = (count_q != '0);
	assign cmd.cmd   = mem_q[rd_ptr_q];
	assign pop_ok    = take && cmd.valid;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= cmd_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push_ok, pop_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/swce_back.sv
// swce_back: channel state (timer, duty, length, envelope, registers) and
// command execution, one command per cycle when rq_full is low; depends on swce_pkg
`default_nettype none

module swce_back
	import swce_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cmd_beat_t cmd,
	output logic           take,
	input  wire logic      rq_full,
	output out_beat_t      res
);

	logic [2:0]  duty_pos_q,   duty_pos_d;
	logic [13:0] freq_cnt_q,   freq_cnt_d;
	logic [10:0] freq_q,       freq_d;
	logic [2:0]  env_cnt_q,    env_cnt_d;
	logic [3:0]  vol_q,        vol_d;
	logic [6:0]  len_q,        len_d;
	logic [1:0]  duty_sel_q,   duty_sel_d;
	logic        env_inc_q,    env_inc_d;
	logic [3:0]  env_start_q,  env_start_d;
	logic [2:0]  env_per_q,    env_per_d;
	logic        len_en_q,     len_en_d;
	logic        enabled_q,    enabled_d;
	logic [4:0]  dac_q,        dac_d;
	logic [13:0] freq_reload;
	logic [11:0] freq_diff;
	logic [2:0]  env_dec;
	logic [7:0]  rd;
	logic [7:0]  pat;
	logic [7:0]  d;

	assign take      = cmd.valid && !rq_full;
	assign d         = cmd.cmd.data;
	assign freq_diff = 12'd2048 - {1'b0, freq_q};
	assign freq_reload = {freq_diff, 2'b00};
	assign env_dec   = (env_cnt_q != 3'd0) ? env_cnt_q - 3'd1 : env_cnt_q;

	always_comb begin
		duty_pos_d  = duty_pos_q;
		freq_cnt_d  = freq_cnt_q;
		freq_d      = freq_q;
		env_cnt_d   = env_cnt_q;
		vol_d       = vol_q;
		len_d       = len_q;
		duty_sel_d  = duty_sel_q;
		env_inc_d   = env_inc_q;
		env_start_d = env_start_q;
		env_per_d   = env_per_q;
		len_en_d    = len_en_q;
		enabled_d   = enabled_q;
		dac_d       = dac_q;
		rd          = 8'hFF;
		case (cmd.cmd.op)
			CMD_WR_DUTY: begin
				duty_sel_d = d[7:6];
				len_d      = 7'd64 - {1'b0, d[5:0]};
			end
			CMD_WR_ENV: begin
				env_inc_d   = d[3];
				env_start_d = d[7:4];
				env_per_d   = d[2:0];
				dac_d       = d[7:3];
				if (d[7:3] == 5'd0) begin
					enabled_d = 1'b0;
				end
			end
			CMD_WR_FLO: freq_d = {freq_q[10:8], d};
			CMD_WR_FHI: begin
				freq_d   = {d[2:0], freq_q[7:0]};
				len_en_d = d[6];
				if (d[7] && (dac_q != 5'd0)) begin
					if (len_q == 7'd0) begin
						len_d = 7'd64;
					end
					enabled_d = 1'b1;
					env_cnt_d = env_per_q;
					vol_d     = env_start_q;
				end
			end
			CMD_RD_DUTY: rd = {duty_sel_q, 6'h3F};
			CMD_RD_ENV:  rd = {env_start_q, env_inc_q, env_per_q};
			CMD_RD_FHI:  rd = {1'b1, len_en_q, 6'h3F};
			CMD_TICK: begin
				if (freq_cnt_q == 14'd0) begin
					freq_cnt_d = freq_reload - 14'd1;
					duty_pos_d = duty_pos_q + 3'd1;
				end else begin
					freq_cnt_d = freq_cnt_q - 14'd1;
				end
			end
			CMD_LENGTH: begin
				if (len_en_q && (len_q != 7'd0)) begin
					len_d = len_q - 7'd1;
					if (len_q == 7'd1) begin
						enabled_d = 1'b0;
					end
				end
			end
			CMD_ENVELOPE: begin
				if (env_per_q != 3'd0) begin
					env_cnt_d = env_dec;
					if (env_dec == 3'd0) begin
						env_cnt_d = env_per_q;
						if (env_inc_q) begin
							if (vol_q != 4'hF) begin
								vol_d = vol_q + 4'd1;
							end
						end else if (vol_q != 4'd0) begin
							vol_d = vol_q - 4'd1;
						end
					end
				end
			end
			default: rd = 8'hFF;
		endcase
	end

	assign pat = duty_pattern(duty_sel_d);

	always_comb begin
		res.read_data  = rd;
		res.channel_on = enabled_d;
		res.sample_out = (enabled_d && pat[~duty_pos_d]) ? vol_d : 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_pos_q  <= '0;
			freq_cnt_q  <= '0;
			freq_q      <= '0;
			env_cnt_q   <= '0;
			vol_q       <= '0;
			len_q       <= '0;
			duty_sel_q  <= '0;
			env_inc_q   <= 1'b0;
			env_start_q <= '0;
			env_per_q   <= '0;
			len_en_q    <= 1'b0;
			enabled_q   <= 1'b0;
			dac_q       <= '0;
		end else if (take) begin
			duty_pos_q  <= duty_pos_d;
			freq_cnt_q  <= freq_cnt_d;
			freq_q      <= freq_d;
			env_cnt_q   <= env_cnt_d;
			vol_q       <= vol_d;
			len_q       <= len_d;
			duty_sel_q  <= duty_sel_d;
			env_inc_q   <= env_inc_d;
			env_start_q <= env_start_d;
			env_per_q   <= env_per_d;
			len_en_q    <= len_en_d;
			enabled_q   <= enabled_d;
			dac_q       <= dac_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/swce_outq.sv
// swce_outq: two-entry result queue between the back end and the result port
// depends on swce_pkg
`default_nettype none

module swce_outq
	import swce_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr,
	input  wire out_beat_t wr_data,
	output logic           rq_full,
	output logic           empty,
	input  wire logic      pop,
	output out_beat_t      result
);

	out_beat_t          mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0]   wr_ptr_q;
	logic [RQ_AW-1:0]   rd_ptr_q;
	logic [RQ_AW:0]     count_q;
	logic               pop_ok;

	assign rq_full = (count_q == (RQ_AW+1)'(RQ_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_ok  = pop && !empty;
	assign result  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr, pop_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/square_wave_channel_with_envelope.sv
// square_wave_channel_with_envelope: top level of the pulse channel
// depends on swce_pkg, swce_front, swce_back and swce_outq
//
// usage: events enter as beats on the input queue port (push/full, item)
// and every event gives exactly one result beat on the output queue port
// (empty/pop, result), in order. an input beat is taken when push is high
// and full is low; a result beat leaves when pop is high and empty is low.
// an input beat is decoded into the command queue, then executed into the
// result queue, and from there it reaches the result port.
// throughput: one beat per cycle while the result queue has room, set by
// the execute stage that updates the timer, length, envelope and register state.
// the four-entry command queue and two-entry result queue let both sides
// stall on their own; when pop stays low the result queue fills, execution
// halts and the command queue then fills, raising full.
// reset: arst_n low clears all channel state to zero and empties both queues.
`default_nettype none

module square_wave_channel_with_envelope
	import swce_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	output logic           full,
	input  wire in_beat_t  item,
	output logic           empty,
	input  wire logic      pop,
	output out_beat_t      result
);

	cmd_beat_t cmd;
	logic      take;
	logic      rq_full;
	out_beat_t res;

	swce_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.cmd    (cmd),
		.take   (take)
	);

	swce_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.take    (take),
		.rq_full (rq_full),
		.res     (res)
	);

	swce_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (take),
		.wr_data (res),
		.rq_full (rq_full),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	a_cmd_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> cmd.valid)
		else $error("accepted beat missing from command queue");

	a_result_queued: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !empty)
		else $error("executed command produced no result beat");

	a_silent_off: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.channel_on) |-> (result.sample_out == 4'd0))
		else $error("sample nonzero while channel is off");

endmodule

`default_nettype wire
